### hdl/ptfa_pkg.sv
package ptfa_pkg;

    localparam int SLOTS_DEFAULT = 4;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_EXT     = 3'd2;
    localparam logic [2:0] ST_NOSPACE = 3'd3;
    localparam logic [2:0] ST_ZERO    = 3'd4;
    localparam logic [2:0] ST_EMPTY   = 3'd5;

    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    localparam logic [1:0] CFG_FIT_MODE   = 2'd0;
    localparam logic [1:0] CFG_DISK_SIZE  = 2'd1;
    localparam logic [1:0] CFG_TABLE_BASE = 2'd2;

    localparam logic KIND_ALLOC   = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [30:0] req_size;
        logic        is_extended;
        logic [1:0]  release_slot;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [30:0] start_addr;
        logic [1:0]  slot;
    } t_out_item;

    typedef struct packed {
        logic        sub;
        logic [31:0] a;
        logic [31:0] b;
    } t_alu_req;

endpackage

### hdl/ptfa_addsub.sv
module ptfa_addsub (
    input  ptfa_pkg::t_alu_req i_req,
    output logic [32:0]        o_sum
);

    logic [32:0] w_b;

    assign w_b   = i_req.sub ? {1'b0, ~i_req.b} : {1'b0, i_req.b};
    assign o_sum = {1'b0, i_req.a} + w_b + {32'd0, i_req.sub};

endmodule

### hdl/partition_table_fit_allocator.sv
// Allocate: check zero size, a second extended entry and a full table, then scan the gaps
// (S_GAP and S_DECIDE per gap, S_END per used slot), find the sorted insertion slot (S_POS)
// and insert; no space is reported after the scan. The shared adder forms gaps and slot ends.
// One item is in work at a time: the input is ready only while the sequencer is idle, so the
// next item is taken only once the result is registered, and a held result stalls the emit.
// Synchronous active-low reset empties the table and loads fit_mode 1, disk_size 0, base 0.
module partition_table_fit_allocator #(
    parameter int SLOTS = ptfa_pkg::SLOTS_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ptfa_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ptfa_pkg::t_out_item o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [30:0]         i_cfg_data
);

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_GAP,
        S_DECIDE,
        S_END,
        S_POS,
        S_INSERT,
        S_RELEASE,
        S_EMIT
    } t_state;

    t_state              r_state;
    ptfa_pkg::t_in_item  r_req;
    ptfa_pkg::t_out_item r_res;
    ptfa_pkg::t_out_item r_out;
    logic                r_out_valid;

    logic [1:0]  r_fit_mode;
    logic [30:0] r_disk;
    logic [15:0] r_base;

    logic        r_valid [SLOTS];
    logic [30:0] r_start [SLOTS];
    logic [30:0] r_len   [SLOTS];
    logic        r_ext   [SLOTS];

    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_used;
    logic [31:0]   r_prev_end;
    logic [30:0]   r_glen;
    logic [30:0]   r_best_start;
    logic [30:0]   r_best_len;
    logic          r_found;

    logic [CW-1:0]      w_used;
    logic               w_have_ext;
    logic [IW-1:0]      w_idx;
    logic [IW-1:0]      w_rel_idx;
    logic               w_rel_ok;
    logic               w_more;
    logic [30:0]        w_gend;
    ptfa_pkg::t_alu_req w_alu_req;
    logic [32:0]        w_sum;
    logic               w_fits;
    logic               w_take;
    logic [SLOTS-1:0]   w_valid_vec;
    logic [SLOTS-1:0]   w_valid_inc;

    always_comb begin
        w_used     = '0;
        w_have_ext = 1'b0;
        for (int k = 0; k < SLOTS; k++) begin
            w_used      = w_used + CW'(r_valid[k]);
            w_have_ext  = w_have_ext | (r_valid[k] & r_ext[k]);
            w_valid_vec[k] = r_valid[k];
        end
    end

    assign w_valid_inc = w_valid_vec + SLOTS'(1);
    assign w_idx       = r_cnt[IW-1:0];
    assign w_rel_idx   = IW'(r_req.release_slot);
    assign w_rel_ok    = (int'(r_req.release_slot) < SLOTS) && r_valid[w_rel_idx];
    assign w_more      = r_cnt < r_used;
    assign w_gend      = w_more ? r_start[w_idx] : r_disk;

    always_comb begin
        if (r_state == S_END) begin
            w_alu_req.sub = 1'b0;
            w_alu_req.a   = {1'b0, r_start[w_idx]};
            w_alu_req.b   = {1'b0, r_len[w_idx]};
        end else begin
            w_alu_req.sub = 1'b1;
            w_alu_req.a   = {1'b0, w_gend};
            w_alu_req.b   = r_prev_end;
        end
    end

    ptfa_addsub u_addsub (
        .i_req (w_alu_req),
        .o_sum (w_sum)
    );

    always_comb begin
        w_fits = r_glen >= r_req.req_size;
        w_take = 1'b0;
        if (w_fits) begin
            if (!r_found) begin
                w_take = 1'b1;
            end else if (r_fit_mode == ptfa_pkg::FIT_BEST) begin
                w_take = r_glen < r_best_len;
            end else if (r_fit_mode == ptfa_pkg::FIT_WORST) begin
                w_take = r_glen > r_best_len;
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_mode <= ptfa_pkg::FIT_BEST;
            r_disk     <= '0;
            r_base     <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ptfa_pkg::CFG_FIT_MODE:   r_fit_mode <= i_cfg_data[1:0];
                ptfa_pkg::CFG_DISK_SIZE:  r_disk     <= i_cfg_data;
                ptfa_pkg::CFG_TABLE_BASE: r_base     <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int k = 0; k < SLOTS; k++) begin
                r_valid[k] <= 1'b0;
            end
        end else begin
            if (r_out_valid && i_out_ready && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_req   <= i_in_data;
                        r_state <= (i_in_data.kind == ptfa_pkg::KIND_ALLOC) ? S_CHECK : S_RELEASE;
                    end
                end
                S_CHECK: begin
                    if (r_req.req_size == '0) begin
                        r_res   <= '{status: ptfa_pkg::ST_ZERO, start_addr: '0, slot: '0};
                        r_state <= S_EMIT;
                    end else if (r_req.is_extended && w_have_ext) begin
                        r_res   <= '{status: ptfa_pkg::ST_EXT, start_addr: '0, slot: '0};
                        r_state <= S_EMIT;
                    end else if (int'(w_used) >= SLOTS) begin
                        r_res   <= '{status: ptfa_pkg::ST_FULL, start_addr: '0, slot: '0};
                        r_state <= S_EMIT;
                    end else begin
                        r_used     <= w_used;
                        r_cnt      <= '0;
                        r_prev_end <= {16'd0, r_base};
                        r_found    <= 1'b0;
                        r_state    <= S_GAP;
                    end
                end
                S_GAP: begin
                    r_glen  <= w_sum[32] ? w_sum[30:0] : '0;
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    if (w_take) begin
                        r_found      <= 1'b1;
                        r_best_start <= r_prev_end[30:0];
                        r_best_len   <= r_glen;
                    end
                    if (w_more) begin
                        r_state <= S_END;
                    end else if (r_found || w_take) begin
                        r_cnt   <= '0;
                        r_state <= S_POS;
                    end else begin
                        r_res   <= '{status: ptfa_pkg::ST_NOSPACE, start_addr: '0, slot: '0};
                        r_state <= S_EMIT;
                    end
                end
                S_END: begin
                    if (w_sum[31:0] > r_prev_end) begin
                        r_prev_end <= w_sum[31:0];
                    end
                    r_cnt   <= r_cnt + CW'(1);
                    r_state <= S_GAP;
                end
                S_POS: begin
                    if (w_more && (r_start[w_idx] < r_best_start)) begin
                        r_cnt <= r_cnt + CW'(1);
                    end else begin
                        r_state <= S_INSERT;
                    end
                end
                S_INSERT: begin
                    for (int k = 1; k < SLOTS; k++) begin
                        if ((CW'(k) > r_cnt) && (CW'(k) <= r_used)) begin
                            r_valid[k] <= r_valid[k-1];
                            r_start[k] <= r_start[k-1];
                            r_len[k]   <= r_len[k-1];
                            r_ext[k]   <= r_ext[k-1];
                        end
                    end
                    for (int k = 0; k < SLOTS; k++) begin
                        if (CW'(k) == r_cnt) begin
                            r_valid[k] <= 1'b1;
                            r_start[k] <= r_best_start;
                            r_len[k]   <= r_req.req_size;
                            r_ext[k]   <= r_req.is_extended;
                        end
                    end
                    r_res   <= '{status: ptfa_pkg::ST_OK, start_addr: r_best_start,
                                 slot: 2'(r_cnt)};
                    r_state <= S_EMIT;
                end
                S_RELEASE: begin
                    if (w_rel_ok) begin
                        for (int k = 0; k < SLOTS - 1; k++) begin
                            if (IW'(k) >= w_rel_idx) begin
                                r_valid[k] <= r_valid[k+1];
                                r_start[k] <= r_start[k+1];
                                r_len[k]   <= r_len[k+1];
                                r_ext[k]   <= r_ext[k+1];
                            end
                        end
                        r_valid[SLOTS-1] <= 1'b0;
                        r_start[SLOTS-1] <= '0;
                        r_len[SLOTS-1]   <= '0;
                        r_ext[SLOTS-1]   <= 1'b0;
                        r_res <= '{status: ptfa_pkg::ST_OK, start_addr: '0, slot: '0};
                    end else begin
                        r_res <= '{status: ptfa_pkg::ST_EMPTY, start_addr: '0, slot: '0};
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_compacted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid_inc & w_valid_vec) == '0)
        else $error("valid slots are not packed at the bottom of the table");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INSERT) |=> ($countones(w_valid_vec) == $past($countones(w_valid_vec)) + 1))
        else $error("insert did not add exactly one slot");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_GAP) || (r_state == S_DECIDE) || (r_state == S_POS)) |-> (r_cnt <= r_used))
        else $error("scan index ran past the used slots");

    a_error_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EMIT) && (r_res.status != ptfa_pkg::ST_OK)) |->
            ((r_res.start_addr == '0) && (r_res.slot == '0)))
        else $error("error result carries a nonzero address or slot");

endmodule
